/* hdl/bal_pkg.sv */
// shared constants, codes and types of the bounded array list engine
package bal_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned DW    = 32;
  localparam int unsigned SUM_W = 36;
  localparam int unsigned OP_W  = 3;

  typedef enum logic [OP_W-1:0] {
    OP_QUERY   = 3'd0,
    OP_APPEND  = 3'd1,
    OP_INSERT  = 3'd2,
    OP_REMOVE  = 3'd3,
    OP_UPDATE  = 3'd4,
    OP_REVERSE = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_MISS  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef struct packed {
    logic             seen;
    logic [AW-1:0]    first;
    logic [CW-1:0]    occ;
    logic [SUM_W-1:0] sum;
    logic [DW-1:0]    big;
  } scan_res_t;

endpackage

/* hdl/bal_ram.sv */
// generic single-write, single-read synchronous ram with registered read data
module bal_ram #(
  parameter int unsigned DataW = 32,
  parameter int unsigned AddrW = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem [2**AddrW];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/bal_scan.sv */
// running statistics over entries streamed out of the list memory
module bal_scan import bal_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          vld_i,
  input  logic [AW-1:0] idx_i,
  input  logic [DW-1:0] data_i,
  input  logic [DW-1:0] key_i,
  output scan_res_t     res_o
);

  logic             seen_q, seen_d;
  logic [AW-1:0]    first_q, first_d;
  logic [CW-1:0]    occ_q, occ_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic [DW-1:0]    big_q, big_d;
  logic             hit;
  logic [SUM_W-1:0] ext;

  assign hit = (data_i == key_i);
  assign ext = {{(SUM_W-DW){data_i[DW-1]}}, data_i};

  always_comb begin
    seen_d  = seen_q;
    first_d = first_q;
    occ_d   = occ_q;
    sum_d   = sum_q;
    big_d   = big_q;
    if (vld_i) begin
      if (idx_i == '0) begin
        // first entry restarts the accumulation
        seen_d  = hit;
        first_d = '0;
        occ_d   = CW'(hit);
        sum_d   = ext;
        big_d   = data_i;
      end else begin
        seen_d = seen_q | hit;
        if (hit && !seen_q) begin
          first_d = idx_i;
        end
        occ_d = occ_q + CW'(hit);
        sum_d = sum_q + ext;
        if ($signed(data_i) > $signed(big_q)) begin
          big_d = data_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q  <= 1'b0;
      first_q <= '0;
      occ_q   <= '0;
      sum_q   <= '0;
      big_q   <= '0;
    end else begin
      seen_q  <= seen_d;
      first_q <= first_d;
      occ_q   <= occ_d;
      sum_q   <= sum_d;
      big_q   <= big_d;
    end
  end

  assign res_o = '{seen: seen_q, first: first_q, occ: occ_q, sum: sum_q, big: big_q};

endmodule

/* hdl/bounded_array_list_engine.sv */
// top level of the bounded array list engine: sequencer, list memory and scan unit
// one item at a time: the engine is ready for the next once the result is registered
// reset clears the fill count and handshake state, not the list memory; a held result stalls
module bounded_array_list_engine import bal_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [OP_W-1:0]         op_i,
  input  logic signed [DW-1:0]    value_i,
  input  logic [CW-1:0]           position_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [1:0]              status_o,
  output logic [CW-1:0]           count_o,
  output logic                    found_o,
  output logic [AW-1:0]           first_slot_o,
  output logic [CW-1:0]           occurrences_o,
  output logic signed [SUM_W-1:0] total_o,
  output logic signed [DW-1:0]    largest_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SHIFT,
    S_DRAIN,
    S_PUT,
    S_FIND,
    S_FIND_WAIT,
    S_FIND_CHK,
    S_SW_RLO,
    S_SW_RHI,
    S_SW_WLO,
    S_SW_WHI,
    S_SCAN,
    S_SCAN_WAIT,
    S_DONE
  } state_e;

  // sequencer state
  state_e           state_q, state_d;
  logic [OP_W-1:0]  op_q, op_d;
  logic [DW-1:0]    value_q, value_d;
  logic [CW-1:0]    pos_q, pos_d;
  logic [CW-1:0]    fill_q, fill_d;
  status_e          status_q, status_d;
  logic [AW-1:0]    cnt_q, cnt_d;      // shift source, low swap slot or scan index
  logic [AW-1:0]    hi_q, hi_d;        // high swap slot
  logic [DW-1:0]    tmp_q, tmp_d;      // low entry held across a swap
  logic             pend_q, pend_d;    // shift read in flight, write it back next cycle
  logic [AW-1:0]    pdst_q, pdst_d;
  logic             svld_q, svld_d;    // scan read in flight
  logic [AW-1:0]    sidx_q, sidx_d;

  // output register
  logic             ovld_q, ovld_d;
  logic [1:0]       ostat_q, ostat_d;
  logic [CW-1:0]    ocnt_q, ocnt_d;
  logic             ofnd_q, ofnd_d;
  logic [AW-1:0]    ofirst_q, ofirst_d;
  logic [CW-1:0]    oocc_q, oocc_d;
  logic [SUM_W-1:0] osum_q, osum_d;
  logic [DW-1:0]    obig_q, obig_d;

  // memory port
  logic             we, re;
  logic [AW-1:0]    waddr, raddr;
  logic [DW-1:0]    wdata, rdata;

  scan_res_t        sres;
  logic [AW-1:0]    fill_m1;
  logic             full, empty;

  assign fill_m1 = AW'(fill_q - CW'(1));
  assign full    = (fill_q == CW'(DEPTH));
  assign empty   = (fill_q == '0);

  bal_ram #(
    .DataW (DW),
    .AddrW (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  bal_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (svld_q),
    .idx_i  (sidx_q),
    .data_i (rdata),
    .key_i  (value_q),
    .res_o  (sres)
  );

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    value_d  = value_q;
    pos_d    = pos_q;
    fill_d   = fill_q;
    status_d = status_q;
    cnt_d    = cnt_q;
    hi_d     = hi_q;
    tmp_d    = tmp_q;
    pend_d   = 1'b0;
    pdst_d   = pdst_q;
    svld_d   = 1'b0;
    sidx_d   = sidx_q;
    ovld_d   = ovld_q;
    ostat_d  = ostat_q;
    ocnt_d   = ocnt_q;
    ofnd_d   = ofnd_q;
    ofirst_d = ofirst_q;
    oocc_d   = oocc_q;
    osum_d   = osum_q;
    obig_d   = obig_q;

    we    = 1'b0;
    waddr = pdst_q;
    wdata = rdata;
    re    = 1'b0;
    raddr = cnt_q;

    // shifted entry arrives in the cycle after its read, write it to its new slot
    if (pend_q) begin
      we = 1'b1;
    end

    if (ovld_q && out_ready_i) begin
      ovld_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d     = op_i;
          value_d  = value_i;
          pos_d    = position_i;
          cnt_d    = '0;
          status_d = ST_OK;
          state_d  = S_SCAN;
          case (op_i)
            OP_APPEND: begin
              if (full) begin
                status_d = ST_FULL;
              end else begin
                pos_d   = fill_q;
                state_d = S_PUT;
              end
            end
            OP_INSERT: begin
              if (full) begin
                status_d = ST_FULL;
              end else if (position_i > fill_q) begin
                status_d = ST_RANGE;
              end else if (position_i == fill_q) begin
                state_d = S_PUT;
              end else begin
                cnt_d   = fill_m1;
                state_d = S_SHIFT;
              end
            end
            OP_REMOVE: begin
              if (empty) begin
                status_d = ST_MISS;
              end else begin
                state_d = S_FIND;
              end
            end
            OP_UPDATE: begin
              if (position_i >= fill_q) begin
                status_d = ST_RANGE;
              end else begin
                state_d = S_PUT;
              end
            end
            OP_REVERSE: begin
              if (fill_q >= CW'(2)) begin
                hi_d    = fill_m1;
                state_d = S_SW_RLO;
              end
            end
            default: begin
              status_d = ST_OK;
            end
          endcase
        end
      end

      S_SHIFT: begin
        re     = 1'b1;
        pend_d = 1'b1;
        if (op_q == OP_INSERT) begin
          // moving up: read downward from the tail
          pdst_d = cnt_q + AW'(1);
          if (cnt_q == AW'(pos_q)) begin
            state_d = S_DRAIN;
          end else begin
            cnt_d = cnt_q - AW'(1);
          end
        end else begin
          // moving down: read upward from the slot after the removed one
          pdst_d = cnt_q - AW'(1);
          if (cnt_q == fill_m1) begin
            state_d = S_DRAIN;
          end else begin
            cnt_d = cnt_q + AW'(1);
          end
        end
      end

      S_DRAIN: begin
        if (op_q == OP_INSERT) begin
          state_d = S_PUT;
        end else begin
          fill_d  = fill_q - CW'(1);
          cnt_d   = '0;
          state_d = S_SCAN;
        end
      end

      S_PUT: begin
        we    = 1'b1;
        waddr = AW'(pos_q);
        wdata = value_q;
        if (op_q != OP_UPDATE) begin
          fill_d = fill_q + CW'(1);
        end
        cnt_d   = '0;
        state_d = S_SCAN;
      end

      S_FIND: begin
        re     = 1'b1;
        svld_d = 1'b1;
        sidx_d = cnt_q;
        if (cnt_q == fill_m1) begin
          state_d = S_FIND_WAIT;
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end

      S_FIND_WAIT: begin
        state_d = S_FIND_CHK;
      end

      S_FIND_CHK: begin
        cnt_d   = '0;
        state_d = S_SCAN;
        if (!sres.seen) begin
          status_d = ST_MISS;
        end else if (sres.first == fill_m1) begin
          // removing the tail entry needs no shift
          fill_d = fill_q - CW'(1);
        end else begin
          cnt_d   = sres.first + AW'(1);
          state_d = S_SHIFT;
        end
      end

      S_SW_RLO: begin
        re      = 1'b1;
        raddr   = cnt_q;
        state_d = S_SW_RHI;
      end

      S_SW_RHI: begin
        tmp_d   = rdata;
        re      = 1'b1;
        raddr   = hi_q;
        state_d = S_SW_WLO;
      end

      S_SW_WLO: begin
        we      = 1'b1;
        waddr   = cnt_q;
        wdata   = rdata;
        state_d = S_SW_WHI;
      end

      S_SW_WHI: begin
        we    = 1'b1;
        waddr = hi_q;
        wdata = tmp_q;
        if ((cnt_q + AW'(1)) < (hi_q - AW'(1))) begin
          cnt_d   = cnt_q + AW'(1);
          hi_d    = hi_q - AW'(1);
          state_d = S_SW_RLO;
        end else begin
          cnt_d   = '0;
          state_d = S_SCAN;
        end
      end

      S_SCAN: begin
        if (empty) begin
          state_d = S_DONE;
        end else begin
          re     = 1'b1;
          svld_d = 1'b1;
          sidx_d = cnt_q;
          if (cnt_q == fill_m1) begin
            state_d = S_SCAN_WAIT;
          end else begin
            cnt_d = cnt_q + AW'(1);
          end
        end
      end

      S_SCAN_WAIT: begin
        state_d = S_DONE;
      end

      S_DONE: begin
        // hold the result until the output register is free
        if (!ovld_q || out_ready_i) begin
          ovld_d  = 1'b1;
          ostat_d = status_q;
          ocnt_d  = fill_q;
          if (empty) begin
            ofnd_d   = 1'b0;
            ofirst_d = '0;
            oocc_d   = '0;
            osum_d   = '0;
            obig_d   = '0;
          end else begin
            ofnd_d   = sres.seen;
            ofirst_d = sres.seen ? sres.first : '0;
            oocc_d   = sres.occ;
            osum_d   = sres.sum;
            obig_d   = sres.big;
          end
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      op_q     <= '0;
      value_q  <= '0;
      pos_q    <= '0;
      fill_q   <= '0;
      status_q <= ST_OK;
      cnt_q    <= '0;
      hi_q     <= '0;
      tmp_q    <= '0;
      pend_q   <= 1'b0;
      pdst_q   <= '0;
      svld_q   <= 1'b0;
      sidx_q   <= '0;
      ovld_q   <= 1'b0;
      ostat_q  <= '0;
      ocnt_q   <= '0;
      ofnd_q   <= 1'b0;
      ofirst_q <= '0;
      oocc_q   <= '0;
      osum_q   <= '0;
      obig_q   <= '0;
    end else begin
      state_q  <= state_d;
      op_q     <= op_d;
      value_q  <= value_d;
      pos_q    <= pos_d;
      fill_q   <= fill_d;
      status_q <= status_d;
      cnt_q    <= cnt_d;
      hi_q     <= hi_d;
      tmp_q    <= tmp_d;
      pend_q   <= pend_d;
      pdst_q   <= pdst_d;
      svld_q   <= svld_d;
      sidx_q   <= sidx_d;
      ovld_q   <= ovld_d;
      ostat_q  <= ostat_d;
      ocnt_q   <= ocnt_d;
      ofnd_q   <= ofnd_d;
      ofirst_q <= ofirst_d;
      oocc_q   <= oocc_d;
      osum_q   <= osum_d;
      obig_q   <= obig_d;
    end
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = ovld_q;
  assign status_o      = ostat_q;
  assign count_o       = ocnt_q;
  assign found_o       = ofnd_q;
  assign first_slot_o  = ofirst_q;
  assign occurrences_o = oocc_q;
  assign total_o       = osum_q;
  assign largest_o     = obig_q;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(DEPTH))
    else $error("fill count above depth");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q != S_IDLE)
    else $error("accepted item did not start work");

  a_first_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> CW'(first_slot_o) < count_o)
    else $error("first slot beyond used entries");

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> occurrences_o <= count_o && (found_o == (occurrences_o != '0)))
    else $error("occurrence count inconsistent");

  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && count_o == '0 |-> total_o == '0 && largest_o == '0 && !found_o)
    else $error("empty list reports entries");
`endif

endmodule

/* tb/bounded_array_list_engine_tb.sv */
// self-checking testbench of the bounded array list engine: directed table, then random list traffic
`timescale 1ns / 100ps

module bounded_array_list_engine_tb;
  import bal_pkg::*;

  // opcodes that the engine treats as a plain query
  localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;

  localparam logic signed [DW-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam logic signed [DW-1:0] VAL_MIN = 32'sh8000_0000;

  localparam int RANDOM_ITEMS = 500;
  localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
  localparam int DRAIN_CYCLES = 80;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int MAX_SHOWN    = 10;

  // one result of the engine, as the list mirror predicts it
  typedef struct {
    status_e              status;
    logic [CW-1:0]        count;
    logic                 found;
    logic [AW-1:0]        first;
    logic [CW-1:0]        occ;
    logic signed [SUM_W-1:0] total;
    logic signed [DW-1:0] largest;
  } list_report_t;

  // directed stimulus; status and count are typed in only where they are obvious
  typedef struct {
    logic [OP_W-1:0]      op;
    logic signed [DW-1:0] value;
    logic [CW-1:0]        slot;
    int                   reps;
    bit                   typed;
    status_e              status;
    int                   count;
  } plan_row_t;

  localparam int PLAN_ROWS = 19;

  plan_row_t plan [PLAN_ROWS] = '{
    // empty list right after reset
    '{OP_QUERY,   32'sd0,     5'd0,  1,  1'b1, ST_OK,    0},
    '{OP_REMOVE,  32'sd0,     5'd0,  1,  1'b1, ST_MISS,  0},
    '{OP_UPDATE,  32'sd7,     5'd0,  1,  1'b1, ST_RANGE, 0},
    '{OP_INSERT,  32'sd7,     5'd1,  1,  1'b1, ST_RANGE, 0},
    '{OP_REVERSE, 32'sd0,     5'd0,  1,  1'b1, ST_OK,    0},
    // fill with the most negative value, the last one inserted at the end
    '{OP_APPEND,  VAL_MIN,    5'd0,  15, 1'b0, ST_OK,    0},
    '{OP_INSERT,  VAL_MIN,    5'd15, 1,  1'b1, ST_OK,    16},
    // full list: fullness wins over a bad position
    '{OP_APPEND,  32'sd1,     5'd0,  1,  1'b1, ST_FULL,  16},
    '{OP_INSERT,  32'sd1,     5'd16, 1,  1'b1, ST_FULL,  16},
    '{OP_UPDATE,  VAL_MAX,    5'd15, 1,  1'b1, ST_OK,    16},
    '{OP_UPDATE,  32'sd1,     5'd16, 1,  1'b1, ST_RANGE, 16},
    '{OP_REMOVE,  32'sd5,     5'd0,  1,  1'b1, ST_MISS,  16},
    '{OP_REMOVE,  VAL_MIN,    5'd0,  1,  1'b1, ST_OK,    15},
    '{OP_INSERT,  -32'sd1,    5'd0,  1,  1'b1, ST_OK,    16},
    '{OP_REVERSE, VAL_MAX,    5'd0,  1,  1'b0, ST_OK,    0},
    '{OP_SPARE6,  VAL_MIN,    5'd3,  1,  1'b0, ST_OK,    0},
    '{OP_SPARE7,  -32'sd1,    5'd31, 1,  1'b0, ST_OK,    0},
    '{OP_UPDATE,  32'sd0,     5'd31, 1,  1'b1, ST_RANGE, 16},
    '{OP_QUERY,   VAL_MAX,    5'd0,  1,  1'b0, ST_OK,    0}
  };

  logic                    clk;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [OP_W-1:0]         item_op = OP_QUERY;
  logic signed [DW-1:0]    item_value = '0;
  logic [CW-1:0]           item_slot = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [1:0]              rpt_status;
  logic [CW-1:0]           rpt_count;
  logic                    rpt_found;
  logic [AW-1:0]           rpt_first;
  logic [CW-1:0]           rpt_occ;
  logic signed [SUM_W-1:0] rpt_total;
  logic signed [DW-1:0]    rpt_largest;

  bounded_array_list_engine dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .op_i          (item_op),
    .value_i       (item_value),
    .position_i    (item_slot),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .status_o      (rpt_status),
    .count_o       (rpt_count),
    .found_o       (rpt_found),
    .first_slot_o  (rpt_first),
    .occurrences_o (rpt_occ),
    .total_o       (rpt_total),
    .largest_o     (rpt_largest)
  );

  // mirror of the list contents, updated as each item is accepted
  logic signed [DW-1:0] mirror [DEPTH];
  int unsigned          mirror_fill = 0;

  list_report_t pending_reports [$];
  int           failures = 0;
  int           sent = 0;
  int           cycle_count = 0;
  bit           steady = 1'b0;      // no idling on either side while set
  bit           hold_sink = 1'b0;   // asks the receiver for one long hold-off

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("bounded_array_list_engine_tb: errors");
      $finish;
    end
  end

  // apply one item to the mirror and work out the report the engine owes for it
  function automatic list_report_t predict_report(logic [OP_W-1:0] op,
                                                  logic signed [DW-1:0] v,
                                                  logic [CW-1:0] pos);
    list_report_t r;
    longint       acc;
    int           hit;
    logic signed [DW-1:0] swap;
    r.status = ST_OK;
    case (op)
      OP_APPEND: begin
        if (mirror_fill >= DEPTH) r.status = ST_FULL;
        else begin
          mirror[mirror_fill] = v;
          mirror_fill++;
        end
      end
      OP_INSERT: begin
        // full is reported ahead of a bad position
        if (mirror_fill >= DEPTH) r.status = ST_FULL;
        else if (pos > mirror_fill) r.status = ST_RANGE;
        else begin
          for (int j = int'(mirror_fill); j > int'(pos); j--) mirror[j] = mirror[j-1];
          mirror[pos] = v;
          mirror_fill++;
        end
      end
      OP_REMOVE: begin
        hit = -1;
        for (int i = 0; i < int'(mirror_fill); i++)
          if (hit < 0 && mirror[i] == v) hit = i;
        // empty list and absent value both leave the list alone
        if (hit < 0) r.status = ST_MISS;
        else begin
          for (int j = hit; j + 1 < int'(mirror_fill); j++) mirror[j] = mirror[j+1];
          mirror_fill--;
        end
      end
      OP_UPDATE: begin
        if (pos >= mirror_fill) r.status = ST_RANGE;
        else mirror[pos] = v;
      end
      OP_REVERSE: begin
        for (int i = 0; i < int'(mirror_fill / 2); i++) begin
          swap = mirror[i];
          mirror[i] = mirror[mirror_fill-1-i];
          mirror[mirror_fill-1-i] = swap;
        end
      end
      default: r.status = ST_OK;   // query and the spare opcodes
    endcase

    // scan of the used entries
    acc       = 0;
    r.count   = CW'(mirror_fill);
    r.found   = 1'b0;
    r.first   = '0;
    r.occ     = '0;
    r.largest = '0;
    for (int i = 0; i < int'(mirror_fill); i++) begin
      acc += longint'(mirror[i]);
      if (i == 0 || mirror[i] > r.largest) r.largest = mirror[i];
      if (mirror[i] == v) begin
        if (!r.found) r.first = AW'(i);
        r.found = 1'b1;
        r.occ++;
      end
    end
    r.total = SUM_W'(acc);
    return r;
  endfunction

  task automatic note_failure(string what, longint want, longint got);
    failures++;
    if (failures <= MAX_SHOWN)
      $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
  endtask

  // offer one item, hold it until taken, then maybe leave a gap
  task automatic offer_item(logic [OP_W-1:0] op, logic signed [DW-1:0] v, logic [CW-1:0] pos,
                            bit typed, status_e st, int cnt);
    list_report_t rpt;
    int           gap;
    in_valid   <= 1'b1;
    item_op    <= op;
    item_value <= v;
    item_slot  <= pos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    rpt = predict_report(op, v, pos);
    if (typed) begin
      rpt.status = st;
      rpt.count  = CW'(cnt);
    end
    pending_reports.push_back(rpt);
    sent++;
    gap = 0;
    if (!steady) begin
      while ($urandom_range(0, 99) < 37) gap++;
      // now and then a long pause so gaps land in every phase of the engine's work
      if ($urandom_range(0, 99) < 4) gap += $urandom_range(10, 40);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // value mix: a few hot values so searches and removes hit, list members, raw noise
  function automatic logic signed [DW-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      case ($urandom_range(0, 6))
        0: return VAL_MAX;
        1: return VAL_MIN;
        2: return -32'sd1;
        3: return 32'sd0;
        4: return 32'sd1;
        5: return 32'sd2;
        default: return 32'sd3;
      endcase
    end
    if (r < 60 && mirror_fill > 0) return mirror[$urandom_range(0, mirror_fill - 1)];
    return $urandom;
  endfunction

  function automatic logic [CW-1:0] pick_slot(logic [OP_W-1:0] op);
    if ($urandom_range(0, 99) < 15) return CW'($urandom_range(0, 31));
    if (op == OP_INSERT) return CW'($urandom_range(0, mirror_fill));
    if (op == OP_UPDATE && mirror_fill > 0) return CW'($urandom_range(0, mirror_fill - 1));
    return CW'($urandom_range(0, 31));
  endfunction

  // a batch of mostly well-formed traffic that tends to grow or shrink the list
  task automatic churn(bit grow, int n);
    logic [OP_W-1:0]      op;
    logic signed [DW-1:0] v;
    int                   r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (grow)
        op = r < 35 ? OP_APPEND : r < 65 ? OP_INSERT : r < 75 ? OP_REMOVE :
             r < 87 ? OP_UPDATE : r < 93 ? OP_QUERY : r < 97 ? OP_REVERSE : OP_SPARE6;
      else
        op = r < 50 ? OP_REMOVE : r < 60 ? OP_APPEND : r < 68 ? OP_INSERT :
             r < 82 ? OP_UPDATE : r < 90 ? OP_QUERY : r < 96 ? OP_REVERSE : OP_SPARE7;
      v = pick_value();
      // removes mostly name an entry that is there
      if (op == OP_REMOVE && mirror_fill > 0 && $urandom_range(0, 99) < 75)
        v = mirror[$urandom_range(0, mirror_fill - 1)];
      offer_item(op, v, pick_slot(op), 1'b0, ST_OK, 0);
    end
  endtask

  // empty the list, fill it with one value to push the sum and the maximum to an edge, then insert and reverse
  task automatic saturate();
    logic signed [DW-1:0] fill_value;
    while (mirror_fill > 0)
      offer_item(OP_REMOVE, mirror[$urandom_range(0, mirror_fill - 1)], CW'($urandom_range(0, 31)),
                 1'b0, ST_OK, 0);
    case ($urandom_range(0, 2))
      0: fill_value = VAL_MAX;
      1: fill_value = VAL_MIN;
      default: fill_value = $urandom;
    endcase
    while (mirror_fill < DEPTH)
      offer_item(OP_APPEND, fill_value, '0, 1'b0, ST_OK, 0);
    offer_item(OP_INSERT, pick_value(), pick_slot(OP_INSERT), 1'b0, ST_OK, 0);
    offer_item(OP_REVERSE, fill_value, '0, 1'b0, ST_OK, 0);
  endtask

  // stimulus
  initial begin
    bit held;
    bit paused;
    int kind;
    held   = 1'b0;
    paused = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (plan[i])
      repeat (plan[i].reps)
        offer_item(plan[i].op, plan[i].value, plan[i].slot, plan[i].typed, plan[i].status,
                   plan[i].count);

    // random traffic
    while (sent < RANDOM_ITEMS + 40) begin
      // receiver stalls for a long stretch while items keep coming
      if (!held && sent >= 150) begin
        held = 1'b1;
        hold_sink = 1'b1;
      end
      // sender goes quiet until every owed result has come back
      if (!paused && sent >= 300) begin
        paused = 1'b1;
        in_valid <= 1'b0;
        do begin
          @(posedge clk);
        end while (pending_reports.size() != 0);
      end
      steady = (sent >= 350 && sent < 450);

      kind = $urandom_range(0, 99);
      if (kind < 7)
        saturate();
      else if (kind < 20)
        // noise: anything the fields allow
        repeat ($urandom_range(1, 6))
          offer_item(OP_W'($urandom_range(0, 7)), $urandom, CW'($urandom_range(0, 31)),
                     1'b0, ST_OK, 0);
      else
        churn(mirror_fill < DEPTH / 2 ? ($urandom_range(0, 99) < 75)
                                      : ($urandom_range(0, 99) < 30),
              $urandom_range(8, 30));
    end

    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0)
      $display("bounded_array_list_engine_tb: clean");
    else
      $display("bounded_array_list_engine_tb: errors");
    $finish;
  end

  // receiver: random back-pressure, one long hold-off, checks every report taken
  initial begin
    list_report_t want;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (pending_reports.size() == 0)
          note_failure("report with no item waiting", 0, 0);
        else begin
          want = pending_reports.pop_front();
          if (rpt_status !== want.status) note_failure("status", want.status, rpt_status);
          if (rpt_count !== want.count) note_failure("count", want.count, rpt_count);
          if (rpt_found !== want.found) note_failure("found", want.found, rpt_found);
          if (rpt_first !== want.first) note_failure("first_slot", want.first, rpt_first);
          if (rpt_occ !== want.occ) note_failure("occurrences", want.occ, rpt_occ);
          if (rpt_total !== want.total) note_failure("total", want.total, rpt_total);
          if (rpt_largest !== want.largest)
            note_failure("largest", want.largest, rpt_largest);
        end
      end
      if (hold_sink) begin
        // engine fills up behind the waiting report and stops taking items
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_sink = 1'b0;
        out_ready <= 1'b1;
      end else
        out_ready <= steady || ($urandom_range(0, 99) >= 37);
    end
  end

endmodule
